FILE: rtl/htfd_pkg.sv
`timescale 1ns / 1ps

package htfd_pkg;

  // crc-8 parameters of the sensor word check
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // byte positions inside the six-byte frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // conversion constants, results in tenths
  localparam int unsigned TEMP_SPAN   = 1750;
  localparam int unsigned TEMP_OFFSET = 450;
  localparam int unsigned HUM_SPAN    = 1000;
  localparam int unsigned FULL_SCALE  = 65535;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } status_e;

  // one byte of msb-first crc-8, no reflection
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/htfd_if.sv
`timescale 1ns / 1ps

// byte channel into the decoder
interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] resp_byte;
  logic       frame_start;

  modport source (output valid, output resp_byte, output frame_start, input ready);
  modport sink   (input valid, input resp_byte, input frame_start, output ready);
endinterface

// measurement result channel
interface htfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] temp_tenths;
  logic        [9:0]  hum_tenths;
  logic        [1:0]  status;

  modport source (output valid, output temp_tenths, output hum_tenths, output status,
                  input ready);
  modport sink   (input valid, input temp_tenths, input hum_tenths, input status,
                  output ready);
endinterface

FILE: rtl/htfd_convert.sv
`timescale 1ns / 1ps

// scales raw words to tenths: x * span / 65535, truncated, temperature less offset
module htfd_convert (
  input  logic        [15:0] temp_raw_i,
  input  logic        [15:0] hum_raw_i,
  output logic signed [11:0] temp_x10_o,
  output logic        [9:0]  hum_x10_o
);

  logic [26:0] temp_prod;
  logic [10:0] temp_q0;
  logic [16:0] temp_rem;
  logic [10:0] temp_q;
  logic [25:0] hum_prod;
  logic [9:0]  hum_q0;
  logic [16:0] hum_rem;
  logic [9:0]  hum_q;

  // x = hi * 65536 + lo = hi * 65535 + (hi + lo), so one correction step suffices
  always_comb begin
    temp_prod = 27'(temp_raw_i) * 27'(htfd_pkg::TEMP_SPAN);
    temp_q0   = temp_prod[26:16];
    temp_rem  = 17'(temp_q0) + 17'(temp_prod[15:0]);
    temp_q    = temp_q0 + 11'((temp_rem >= 17'(htfd_pkg::FULL_SCALE)) ? 1 : 0);
    temp_x10_o = $signed(12'(temp_q) - 12'(htfd_pkg::TEMP_OFFSET));
  end

  always_comb begin
    hum_prod = 26'(hum_raw_i) * 26'(htfd_pkg::HUM_SPAN);
    hum_q0   = hum_prod[25:16];
    hum_rem  = 17'(hum_q0) + 17'(hum_prod[15:0]);
    hum_q    = hum_q0 + 10'((hum_rem >= 17'(htfd_pkg::FULL_SCALE)) ? 1 : 0);
    hum_x10_o = hum_q;
  end

endmodule

FILE: rtl/humidity_temp_frame_decoder.sv
`timescale 1ns / 1ps

// Decodes the six-byte response of a humidity/temperature sensor.
// in_i carries one frame byte per beat: temperature msb, lsb, crc, then
// humidity msb, lsb, crc. frame_start on a beat restarts the frame at the
// temperature msb and drops any partial frame.
// out_o carries one result per complete frame: temperature and humidity in
// tenths plus a status (ok, temperature crc bad, humidity crc bad; the
// temperature check wins). On a bad status both values read zero.
// Throughput: one byte per cycle while in_i.ready is high. The result
// appears in the cycle after the humidity crc byte's beat; the humidity
// crc compare and the scaling multiply with its reciprocal correction
// sit between the frame state registers and the result register.
// Reset clears the frame position, crc and result valid; the first byte
// after reset is taken as a temperature msb.
// When the receiver stalls, the result register holds its beat; bytes keep
// being accepted until the humidity crc byte is next, so in_i.ready drops
// only while a result waits untaken and that byte is due.
module humidity_temp_frame_decoder (
  input logic        clk_i,
  input logic        rst_ni,
  htfd_in_if.sink    in_i,
  htfd_out_if.source out_o
);

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_seed, crc_next;
  logic [15:0] temp_raw_q, temp_raw_d;
  logic [15:0] hum_raw_q, hum_raw_d;
  logic        temp_bad_q, temp_bad_d;
  logic        accept;
  logic        last_beat;
  logic        hum_bad;
  logic signed [11:0] temp_conv;
  logic        [9:0]  hum_conv;
  htfd_pkg::status_e  status_d;

  logic               out_valid_q;
  logic signed [11:0] out_temp_q;
  logic        [9:0]  out_hum_q;
  htfd_pkg::status_e  out_status_q;

  // hold bytes back only when the next one would produce a result
  assign in_i.ready = ~out_valid_q | out_o.ready | (pos_q != htfd_pkg::POS_H_CRC);
  assign accept     = in_i.valid & in_i.ready;

  // effective position: restart or out-of-range goes back to the first byte
  assign pos_eff = (in_i.frame_start || pos_q > htfd_pkg::POS_H_CRC)
                   ? htfd_pkg::POS_T_MSB : pos_q;

  assign crc_seed = (pos_eff == htfd_pkg::POS_T_MSB || pos_eff == htfd_pkg::POS_H_MSB)
                    ? htfd_pkg::CRC_INIT : crc_q;
  assign crc_next = htfd_pkg::crc8_update(crc_seed, in_i.resp_byte);

  // frame state update per byte
  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    temp_raw_d = temp_raw_q;
    hum_raw_d  = hum_raw_q;
    temp_bad_d = temp_bad_q;
    last_beat  = 1'b0;
    if (accept) begin
      pos_d = (pos_eff == htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_MSB : pos_eff + 3'd1;
      unique case (pos_eff)
        htfd_pkg::POS_T_MSB: begin
          crc_d      = crc_next;
          temp_raw_d = {in_i.resp_byte, 8'h00};
        end
        htfd_pkg::POS_T_LSB: begin
          crc_d      = crc_next;
          temp_raw_d = {temp_raw_q[15:8], in_i.resp_byte};
        end
        htfd_pkg::POS_T_CRC: begin
          temp_bad_d = (crc_q != in_i.resp_byte);
          crc_d      = htfd_pkg::CRC_INIT;
        end
        htfd_pkg::POS_H_MSB: begin
          crc_d     = crc_next;
          hum_raw_d = {in_i.resp_byte, 8'h00};
        end
        htfd_pkg::POS_H_LSB: begin
          crc_d     = crc_next;
          hum_raw_d = {hum_raw_q[15:8], in_i.resp_byte};
        end
        default: begin
          crc_d     = htfd_pkg::CRC_INIT;
          last_beat = 1'b1;
        end
      endcase
    end
  end

  // scaling of the stored words
  htfd_convert u_convert (
    .temp_raw_i (temp_raw_q),
    .hum_raw_i  (hum_raw_q),
    .temp_x10_o (temp_conv),
    .hum_x10_o  (hum_conv)
  );

  // status, temperature check first
  assign hum_bad  = (crc_q != in_i.resp_byte);
  assign status_d = temp_bad_q ? htfd_pkg::STATUS_TEMP_CRC
                  : (hum_bad ? htfd_pkg::STATUS_HUM_CRC : htfd_pkg::STATUS_OK);

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= htfd_pkg::POS_T_MSB;
      crc_q      <= htfd_pkg::CRC_INIT;
      temp_raw_q <= '0;
      hum_raw_q  <= '0;
      temp_bad_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      temp_raw_q <= temp_raw_d;
      hum_raw_q  <= hum_raw_d;
      temp_bad_q <= temp_bad_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_beat) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (last_beat) begin
      out_status_q <= status_d;
      if (status_d == htfd_pkg::STATUS_OK) begin
        out_temp_q <= temp_conv;
        out_hum_q  <= hum_conv;
      end else begin
        out_temp_q <= '0;
        out_hum_q  <= '0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.temp_tenths = out_temp_q;
  assign out_o.hum_tenths  = out_hum_q;
  assign out_o.status      = out_status_q;

endmodule

FILE: rtl/htfd_checker.sv
`timescale 1ns / 1ps

module htfd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic signed [11:0] out_temp_i,
  input logic        [9:0]  out_hum_i,
  input logic        [1:0]  out_status_i
);

  // a stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_temp_i) && $stable(out_hum_i)
                                     && $stable(out_status_i))
    else $error("stalled result changed");

  // an error result carries zero values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != htfd_pkg::STATUS_OK |-> out_temp_i == 12'sd0
                                                          && out_hum_i == 10'd0)
    else $error("error result with nonzero values");

  // a good result stays in humidity range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == htfd_pkg::STATUS_OK |-> out_hum_i <= 10'd1000)
    else $error("humidity out of range");

  // with no result pending the byte channel is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty result register");

  // a new result only follows an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without input beat");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_temp_i   (out_o.temp_tenths),
  .out_hum_i    (out_o.hum_tenths),
  .out_status_i (out_o.status)
);
